### hdl/lsbse_pkg.sv
// Shared types, codes and constants for the LSB steganography embed/extract block.
`default_nettype none
package lsbse_pkg;

    // Field widths
    localparam int CHAN_W     = 8;
    localparam int NIB_W      = 4;
    localparam int POS_W      = 25;
    localparam int LEN_W      = 24;
    localparam int HDR_W      = 32;
    localparam int TOTAL_W    = 25;
    localparam int CFG_DATA_W = 25;
    localparam int CFG_IDX_W  = 2;
    localparam int TDATA_W    = 40;
    localparam int S_TUSER_W  = 1;
    localparam int M_TUSER_W  = 3;

    // Header is eight pixels of one nibble each; extract accepts 1..10000 bytes
    localparam logic [POS_W-1:0] HDR_LAST_POS = POS_W'(7);
    localparam logic [HDR_W-1:0] MAX_LENGTH   = HDR_W'(10000);
    localparam logic [POS_W-1:0] POS_MAX      = {POS_W{1'b1}};

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_MODE      = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MSG_LEN   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_TOTAL_PIX = 2'd2;

    // Modes
    localparam logic MODE_HIDE    = 1'b0;
    localparam logic MODE_EXTRACT = 1'b1;

    typedef enum logic [1:0] {
        PH_HEADER  = 2'd0,
        PH_BODY    = 2'd1,
        PH_DONE    = 2'd2,
        PH_INVALID = 2'd3
    } phase_t;

    typedef enum logic [1:0] {
        ST_WORKING    = 2'd0,
        ST_FINISHED   = 2'd1,
        ST_NO_MESSAGE = 2'd2,
        ST_TOO_LONG   = 2'd3
    } status_t;

    typedef struct packed {
        logic                mode;
        logic [LEN_W-1:0]    message_length;
        logic [TOTAL_W-1:0]  image_pixels;
    } cfg_t;

    typedef struct packed {
        phase_t              phase;
        logic [POS_W-1:0]    pixel_position;
        logic [HDR_W-1:0]    length_shift;
        logic [NIB_W-1:0]    nibble_hold;
        logic [LEN_W-1:0]    bytes_done;
    } state_t;

    typedef struct packed {
        logic                frame_start;
        logic [CHAN_W-1:0]   red;
        logic [CHAN_W-1:0]   green;
        logic [CHAN_W-1:0]   blue;
        logic [CHAN_W-1:0]   alpha;
        logic [CHAN_W-1:0]   message_byte;
    } pixel_in_t;

    typedef struct packed {
        logic [CHAN_W-1:0]   out_red;
        logic [CHAN_W-1:0]   out_green;
        logic [CHAN_W-1:0]   out_blue;
        logic [CHAN_W-1:0]   out_alpha;
        logic                byte_valid;
        logic [CHAN_W-1:0]   byte_value;
        logic                last_byte;
        status_t             status;
    } result_t;

endpackage
`default_nettype wire

### hdl/lsbse_cfg.sv
// Configuration register file: mode, message length and image pixel count.
`default_nettype none
module lsbse_cfg (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            cfg_we,
    input  wire logic [lsbse_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [lsbse_pkg::CFG_DATA_W-1:0] cfg_wdata,
    output lsbse_pkg::cfg_t                      cfg
);

    lsbse_pkg::cfg_t cfg_reg;

    // Register writes; unknown indexes are dropped
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.mode           <= lsbse_pkg::MODE_EXTRACT;
            cfg_reg.message_length <= '0;
            cfg_reg.image_pixels   <= lsbse_pkg::TOTAL_W'(1);
        end else if (cfg_we) begin
            unique case (cfg_index)
                lsbse_pkg::REG_MODE:
                    cfg_reg.mode <= cfg_wdata[0];
                lsbse_pkg::REG_MSG_LEN:
                    cfg_reg.message_length <= cfg_wdata[lsbse_pkg::LEN_W-1:0];
                lsbse_pkg::REG_TOTAL_PIX:
                    cfg_reg.image_pixels <= cfg_wdata[lsbse_pkg::TOTAL_W-1:0];
                default: ;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule
`default_nettype wire

### hdl/lsbse_step.sv
// Per-pixel combinational step: embeds or recovers one nibble and computes next state.
`default_nettype none
module lsbse_step (
    input  wire lsbse_pkg::cfg_t     cfg,
    input  wire lsbse_pkg::state_t   state_cur,
    input  wire lsbse_pkg::pixel_in_t pix,
    output lsbse_pkg::state_t   state_next,
    output lsbse_pkg::result_t  result
);

    lsbse_pkg::state_t          st;          // state after frame restart
    logic [lsbse_pkg::POS_W:0]  need;        // pixels needed to hide message
    logic [lsbse_pkg::POS_W:0]  final_pos;
    logic                       too_long;
    logic                       in_range;
    logic                       is_final;
    logic                       in_header;
    logic [lsbse_pkg::HDR_W-1:0] len_word;
    logic [lsbse_pkg::NIB_W-1:0] hide_nib;
    logic [lsbse_pkg::NIB_W-1:0] pix_nib;
    logic [lsbse_pkg::HDR_W-1:0] shift_new;
    logic                       hdr_end;
    logic                       len_bad;
    logic [lsbse_pkg::LEN_W-1:0] bytes_inc;
    logic                       msg_end;

    // Frame start clears state before the pixel is handled
    always_comb begin
        st = state_cur;
        if (pix.frame_start) begin
            st.phase          = lsbse_pkg::PH_HEADER;
            st.pixel_position = '0;
            st.length_shift   = '0;
            st.nibble_hold    = '0;
            st.bytes_done     = '0;
        end
    end

    // Hide side: capacity check and nibble to embed
    assign need      = {1'b0, cfg.message_length, 1'b0} + (lsbse_pkg::POS_W+1)'(8);
    assign final_pos = need - (lsbse_pkg::POS_W+1)'(1);
    assign too_long  = need > {1'b0, cfg.image_pixels};
    assign in_range  = {1'b0, st.pixel_position} <= final_pos;
    assign is_final  = {1'b0, st.pixel_position} == final_pos;
    assign in_header = (st.pixel_position[lsbse_pkg::POS_W-1:3] == '0);
    assign len_word  = {8'd0, cfg.message_length};
    assign hide_nib  = in_header ? len_word[{~st.pixel_position[2:0], 2'b00} +: 4]
                     : (st.pixel_position[0] ? pix.message_byte[3:0]
                                             : pix.message_byte[7:4]);

    // Extract side: recovered nibble, header and byte bookkeeping
    assign pix_nib   = {pix.red[0], pix.green[0], pix.blue[0], pix.alpha[0]};
    assign shift_new = {st.length_shift[lsbse_pkg::HDR_W-5:0], pix_nib};
    assign hdr_end   = (st.pixel_position == lsbse_pkg::HDR_LAST_POS);
    assign len_bad   = (shift_new == '0) || (shift_new > lsbse_pkg::MAX_LENGTH);
    assign bytes_inc = st.bytes_done + lsbse_pkg::LEN_W'(1);
    assign msg_end   = {8'd0, bytes_inc} >= st.length_shift;

    // Next state
    always_comb begin
        state_next = st;
        if (st.pixel_position != lsbse_pkg::POS_MAX) begin
            state_next.pixel_position = st.pixel_position + lsbse_pkg::POS_W'(1);
        end
        if (cfg.mode == lsbse_pkg::MODE_EXTRACT) begin
            unique case (st.phase)
                lsbse_pkg::PH_HEADER: begin
                    state_next.length_shift = shift_new;
                    if (hdr_end) begin
                        state_next.phase = len_bad ? lsbse_pkg::PH_INVALID
                                                   : lsbse_pkg::PH_BODY;
                    end
                end
                lsbse_pkg::PH_BODY: begin
                    if (!st.pixel_position[0]) begin
                        state_next.nibble_hold = pix_nib;
                    end else begin
                        state_next.bytes_done = bytes_inc;
                        if (msg_end) begin
                            state_next.phase = lsbse_pkg::PH_DONE;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    // Outputs
    always_comb begin
        result.out_red    = pix.red;
        result.out_green  = pix.green;
        result.out_blue   = pix.blue;
        result.out_alpha  = pix.alpha;
        result.byte_valid = 1'b0;
        result.byte_value = '0;
        result.last_byte  = 1'b0;
        result.status     = lsbse_pkg::ST_WORKING;
        if (cfg.mode == lsbse_pkg::MODE_HIDE) begin
            if (too_long) begin
                result.status = lsbse_pkg::ST_TOO_LONG;
            end else if (in_range) begin
                result.out_red   = {pix.red[7:1],   hide_nib[3]};
                result.out_green = {pix.green[7:1], hide_nib[2]};
                result.out_blue  = {pix.blue[7:1],  hide_nib[1]};
                result.out_alpha = {pix.alpha[7:1], hide_nib[0]};
                if (is_final) begin
                    result.last_byte = 1'b1;
                    result.status    = lsbse_pkg::ST_FINISHED;
                end
            end else begin
                result.status = lsbse_pkg::ST_FINISHED;
            end
        end else begin
            unique case (st.phase)
                lsbse_pkg::PH_HEADER: begin
                    if (hdr_end && len_bad) begin
                        result.status = lsbse_pkg::ST_NO_MESSAGE;
                    end
                end
                lsbse_pkg::PH_BODY: begin
                    if (st.pixel_position[0]) begin
                        result.byte_valid = 1'b1;
                        result.byte_value = {st.nibble_hold, pix_nib};
                        if (msg_end) begin
                            result.last_byte = 1'b1;
                            result.status    = lsbse_pkg::ST_FINISHED;
                        end
                    end
                end
                lsbse_pkg::PH_DONE:    result.status = lsbse_pkg::ST_FINISHED;
                lsbse_pkg::PH_INVALID: result.status = lsbse_pkg::ST_NO_MESSAGE;
                default: ;
            endcase
        end
    end

endmodule
`default_nettype wire

### hdl/lsb_stego_embed_extract.sv
// Flow: an accepted item is held in the input register, then its result in the result register.
// Throughput: one pixel per cycle sustained while results are taken; the input register and result register form
//   a two-stage pipeline that advances whenever the result register is free or being taken.
// Reset (aresetn low, synchronous) empties both stages, restores the header state and
//   loads mode extract, message length 0 and total pixels 1.
`default_nettype none
module lsb_stego_embed_extract (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    // Input pixels
    input  wire logic                              s_tvalid,
    output      logic                              s_tready,
    // red, green, blue, alpha, message_byte (low to high)
    input  wire logic [lsbse_pkg::TDATA_W-1:0]     s_tdata,
    // frame_start
    input  wire logic [lsbse_pkg::S_TUSER_W-1:0]   s_tuser,
    // Result pixels
    output      logic                              m_tvalid,
    input  wire logic                              m_tready,
    // out_red, out_green, out_blue, out_alpha, byte_value (low to high)
    output      logic [lsbse_pkg::TDATA_W-1:0]     m_tdata,
    // byte_valid, status (low to high)
    output      logic [lsbse_pkg::M_TUSER_W-1:0]   m_tuser,
    output      logic                              m_tlast,
    // Configuration writes
    input  wire logic                              cfg_we,
    input  wire logic [lsbse_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [lsbse_pkg::CFG_DATA_W-1:0]  cfg_wdata
);

    lsbse_pkg::cfg_t        cfg;
    lsbse_pkg::pixel_in_t   in_reg;
    logic                   in_valid_reg;
    lsbse_pkg::state_t      state_reg;
    lsbse_pkg::state_t      state_next;
    lsbse_pkg::result_t     result_next;
    lsbse_pkg::result_t     out_reg;
    logic                   out_valid_reg;
    logic                   advance;

    lsbse_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    lsbse_step u_step (
        .cfg        (cfg),
        .state_cur  (state_reg),
        .pix        (in_reg),
        .state_next (state_next),
        .result     (result_next)
    );

    // Pipeline handshake
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    // Input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_reg.frame_start  <= s_tuser[0];
            in_reg.red          <= s_tdata[7:0];
            in_reg.green        <= s_tdata[15:8];
            in_reg.blue         <= s_tdata[23:16];
            in_reg.alpha        <= s_tdata[31:24];
            in_reg.message_byte <= s_tdata[39:32];
        end
    end

    // Frame state, updated as each item moves to the result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg.phase          <= lsbse_pkg::PH_HEADER;
            state_reg.pixel_position <= '0;
            state_reg.length_shift   <= '0;
            state_reg.nibble_hold    <= '0;
            state_reg.bytes_done     <= '0;
        end else if (advance) begin
            state_reg <= state_next;
        end
    end

    // Result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_reg <= result_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_reg.byte_value, out_reg.out_alpha, out_reg.out_blue,
                       out_reg.out_green, out_reg.out_red};
    assign m_tuser  = {out_reg.status, out_reg.byte_valid};
    assign m_tlast  = out_reg.last_byte;

    // Recovered bytes only appear in extract mode
    a_byte_mode: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser[0]) |-> (cfg.mode == lsbse_pkg::MODE_EXTRACT))
        else $error("recovered byte while in hide mode");

    // A last mark always comes with finished status
    a_last_status: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tlast) |-> (out_reg.status == lsbse_pkg::ST_FINISHED))
        else $error("last mark without finished status");

    // Pixel position only falls at a frame start
    a_pos_mono: assert property (@(posedge aclk) disable iff (!aresetn)
        !(advance && in_reg.frame_start)
        |=> (state_reg.pixel_position >= $past(state_reg.pixel_position)))
        else $error("pixel position fell without frame start");

    // Body phase is entered only at the last header pixel
    a_body_entry: assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && state_reg.phase == lsbse_pkg::PH_HEADER && !in_reg.frame_start
         && state_next.phase == lsbse_pkg::PH_BODY)
        |-> (state_reg.pixel_position == lsbse_pkg::HDR_LAST_POS))
        else $error("body phase entered away from header end");

    // Too long status never carries a recovered byte or last mark
    a_too_long: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && out_reg.status == lsbse_pkg::ST_TOO_LONG)
        |-> (!m_tuser[0] && !m_tlast))
        else $error("too long status with byte or last mark");

endmodule
`default_nettype wire

### tb/tb_top.sv
// Testbench for the LSB steganography embed/extract block: directed and random pixel frames.
`timescale 1ns / 100ps
module tb_top;
    import lsbse_pkg::*;

    logic                   aclk = 1'b0;
    logic                   aresetn = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    // red, green, blue, alpha, message_byte (low to high)
    logic [TDATA_W-1:0]     s_tdata = '0;
    // frame_start
    logic [S_TUSER_W-1:0]   s_tuser = '0;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    // out_red, out_green, out_blue, out_alpha, byte_value (low to high)
    logic [TDATA_W-1:0]     m_tdata;
    // byte_valid, status (low to high)
    logic [M_TUSER_W-1:0]   m_tuser;
    logic                   m_tlast;
    logic                   cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]   cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_wdata = '0;

    // Register copies and frame state of the predictor
    logic                   cfg_mode = MODE_EXTRACT;
    logic [LEN_W-1:0]       cfg_len = '0;
    logic [TOTAL_W-1:0]     cfg_total = TOTAL_W'(1);
    phase_t                 st_phase = PH_HEADER;
    logic [POS_W-1:0]       st_pos = '0;
    logic [HDR_W-1:0]       st_len = '0;
    logic [NIB_W-1:0]       st_high = '0;
    logic [LEN_W-1:0]       st_bytes = '0;

    result_t                pending_pixels[$];
    int unsigned            src_idle_pct = 0;
    int unsigned            sink_stall_pct = 0;
    int unsigned            mismatches = 0;
    int unsigned            pixels_sent = 0;
    int unsigned            results_seen = 0;
    int unsigned            bytes_seen = 0;
    int unsigned            lasts_seen = 0;
    int unsigned            reg_sets = 0;

    lsb_stego_embed_extract dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    always #5 aclk = ~aclk;

    // Expected output pixel for one accepted input pixel; advances the frame state
    function automatic result_t predict_stego_pixel(pixel_in_t px);
        result_t      res;
        logic [25:0]  need;
        logic [31:0]  len_word;
        logic [3:0]   nib;
        int           sh;
        res.out_red    = px.red;
        res.out_green  = px.green;
        res.out_blue   = px.blue;
        res.out_alpha  = px.alpha;
        res.byte_valid = 1'b0;
        res.byte_value = '0;
        res.last_byte  = 1'b0;
        res.status     = ST_WORKING;
        if (px.frame_start) begin
            st_phase = PH_HEADER;
            st_pos   = '0;
            st_len   = '0;
            st_high  = '0;
            st_bytes = '0;
        end
        if (cfg_mode == MODE_HIDE) begin
            // header is 8 pixels, then two pixels per message byte
            need = {1'b0, cfg_len, 1'b0} + 26'd8;
            if (need > {1'b0, cfg_total}) begin
                res.status = ST_TOO_LONG;
            end else if ({1'b0, st_pos} <= need - 26'd1) begin
                if (st_pos < 25'd8) begin
                    len_word = {8'd0, cfg_len};
                    sh = 28 - 4 * int'(st_pos);
                    nib = 4'(len_word >> sh);
                end else begin
                    nib = st_pos[0] ? px.message_byte[3:0] : px.message_byte[7:4];
                end
                res.out_red   = {px.red[7:1], nib[3]};
                res.out_green = {px.green[7:1], nib[2]};
                res.out_blue  = {px.blue[7:1], nib[1]};
                res.out_alpha = {px.alpha[7:1], nib[0]};
                if ({1'b0, st_pos} == need - 26'd1) begin
                    res.last_byte = 1'b1;
                    res.status    = ST_FINISHED;
                end
            end else begin
                res.status = ST_FINISHED;
            end
        end else begin
            nib = {px.red[0], px.green[0], px.blue[0], px.alpha[0]};
            case (st_phase)
                PH_HEADER: begin
                    st_len = {st_len[27:0], nib};
                    if (st_pos == HDR_LAST_POS) begin
                        if (st_len == '0 || st_len > MAX_LENGTH) begin
                            st_phase   = PH_INVALID;
                            res.status = ST_NO_MESSAGE;
                        end else begin
                            st_phase = PH_BODY;
                        end
                    end
                end
                PH_BODY: begin
                    if (!st_pos[0]) begin
                        st_high = nib;
                    end else begin
                        res.byte_valid = 1'b1;
                        res.byte_value = {st_high, nib};
                        st_bytes = st_bytes + 24'd1;
                        if ({8'd0, st_bytes} >= st_len) begin
                            res.last_byte = 1'b1;
                            res.status    = ST_FINISHED;
                            st_phase      = PH_DONE;
                        end
                    end
                end
                PH_DONE: res.status = ST_FINISHED;
                default: res.status = ST_NO_MESSAGE;
            endcase
        end
        if (st_pos != POS_MAX) st_pos = st_pos + 25'd1;
        return res;
    endfunction

    // Receiver: random backpressure
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(0, 99) >= sink_stall_pct);
        end
    end

    task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
        if (got !== want) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            mismatches++;
        end
    endtask

    // Compare each output item with the oldest expectation
    always @(posedge aclk) begin : result_check
        result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            results_seen++;
            if (m_tuser[0] === 1'b1) bytes_seen++;
            if (m_tlast === 1'b1) lasts_seen++;
            if (pending_pixels.size() == 0) begin
                $error("output item with nothing expected: tdata %0h tuser %0h tlast %0b",
                       m_tdata, m_tuser, m_tlast);
                mismatches++;
            end else begin
                want = pending_pixels.pop_front();
                check_field("out_red", want.out_red, m_tdata[7:0]);
                check_field("out_green", want.out_green, m_tdata[15:8]);
                check_field("out_blue", want.out_blue, m_tdata[23:16]);
                check_field("out_alpha", want.out_alpha, m_tdata[31:24]);
                check_field("byte_value", want.byte_value, m_tdata[39:32]);
                check_field("byte_valid", {7'd0, want.byte_valid}, {7'd0, m_tuser[0]});
                check_field("status", {6'd0, want.status}, {6'd0, m_tuser[2:1]});
                check_field("last_byte", {7'd0, want.last_byte}, {7'd0, m_tlast});
            end
        end
    end

    // Send one pixel, with a random idle gap first; predict its result on acceptance
    task automatic send_pixel(input logic fs, input logic [7:0] r, g, b, a, msg);
        pixel_in_t px;
        if ($urandom_range(0, 99) < src_idle_pct) begin
            s_tvalid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(0, 99) < src_idle_pct);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {msg, a, b, g, r};
        s_tuser  <= fs;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        px.frame_start  = fs;
        px.red          = r;
        px.green        = g;
        px.blue         = b;
        px.alpha        = a;
        px.message_byte = msg;
        pending_pixels.push_back(predict_stego_pixel(px));
        pixels_sent++;
    endtask

    // Pixel with random upper bits whose channel LSBs carry one nibble
    task automatic send_nibble(input logic fs, input logic [3:0] nib);
        send_pixel(fs, {7'($urandom), nib[3]}, {7'($urandom), nib[2]},
                   {7'($urandom), nib[1]}, {7'($urandom), nib[0]}, 8'($urandom));
    endtask

    // Length header then body pixels, as an embedded image would carry them
    task automatic send_extract_frame(input logic [31:0] hdr, input int body, input logic fs);
        for (int i = 0; i < 8; i++) send_nibble(fs && i == 0, hdr[31 - 4 * i -: 4]);
        for (int j = 0; j < body; j++) send_nibble(1'b0, 4'($urandom));
    endtask

    // Cover image for hiding; the message byte is held over both pixels of a byte
    task automatic send_hide_frame(input int n, input logic fs);
        logic [7:0] msg;
        msg = '0;
        for (int i = 0; i < n; i++) begin
            if (i < 8 || i % 2 == 0) msg = 8'($urandom);
            send_pixel(fs && i == 0, 8'($urandom), 8'($urandom), 8'($urandom),
                       8'($urandom), msg);
        end
    endtask

    // Wait until every expected item has come back and the pipeline is empty
    task automatic quiesce();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending_pixels.size() != 0) @(posedge aclk);
        repeat (3) @(posedge aclk);
    endtask

    task automatic write_regs(input logic mode, input logic [23:0] len, input logic [24:0] total);
        quiesce();
        cfg_we    <= 1'b1;
        cfg_index <= REG_MODE;
        cfg_wdata <= CFG_DATA_W'(mode);
        @(posedge aclk);
        cfg_index <= REG_MSG_LEN;
        cfg_wdata <= CFG_DATA_W'(len);
        @(posedge aclk);
        cfg_index <= REG_TOTAL_PIX;
        cfg_wdata <= CFG_DATA_W'(total);
        @(posedge aclk);
        cfg_we <= 1'b0;
        @(posedge aclk);
        cfg_mode  = mode;
        cfg_len   = len;
        cfg_total = total;
        reg_sets++;
    endtask

    task automatic set_pressure(input int p);
        case (p)
            0: begin src_idle_pct = 0;  sink_stall_pct = 0;  end
            1: begin src_idle_pct = 85; sink_stall_pct = 0;  end
            2: begin src_idle_pct = 0;  sink_stall_pct = 85; end
            default: begin src_idle_pct = 16; sink_stall_pct = 16; end
        endcase
    endtask

    // Hide settings around the capacity boundary, extremes included
    task automatic pick_hide_setup(output logic [23:0] len, output logic [24:0] total);
        int          sel;
        logic [25:0] need;
        logic [25:0] t;
        sel = $urandom_range(0, 99);
        if (sel < 65) len = 24'($urandom_range(0, 10));
        else if (sel < 80) len = 24'($urandom);
        else if (sel < 90) len = 24'hFFFFFF;
        else len = 24'd8388604;
        need = {1'b0, len, 1'b0} + 26'd8;
        sel = $urandom_range(0, 99);
        if (sel < 35) t = need;
        else if (sel < 50) t = need - 26'd1;
        else if (sel < 75) t = need + 26'($urandom_range(1, 6));
        else if (sel < 85) t = 26'h1000000;
        else if (sel < 92) t = 26'($urandom_range(0, 1));
        else t = 26'($urandom_range(0, 32'h1000000));
        if (t > 26'h1000000) t = 26'h1000000;
        total = t[24:0];
    endtask

    // Reset settings (extract): one short message, then a header with the sign bit set
    task automatic test_directed_extract();
        send_extract_frame(32'd1, 2, 1'b1);
        send_extract_frame(32'hFFFF_FFFF, 0, 1'b1);
    endtask

    // Capacity of zero, largest message, empty message with extreme channel values
    task automatic test_directed_hide();
        write_regs(MODE_HIDE, 24'd0, 25'd0);
        send_pixel(1'b1, 8'hFF, 8'h00, 8'hFF, 8'h00, 8'hFF);
        write_regs(MODE_HIDE, 24'hFFFFFF, 25'h1000000);
        send_pixel(1'b1, 8'h00, 8'hFF, 8'h00, 8'hFF, 8'h00);
        write_regs(MODE_HIDE, 24'd0, 25'd8);
        for (int i = 0; i < 9; i++) begin
            if (i % 2 == 0) send_pixel(i == 0, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
            else send_pixel(1'b0, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
        end
    endtask

    // Mostly well-formed frames; some bad headers, truncated bodies, missing frame starts
    task automatic test_random_extract();
        int          budget, sel, body;
        logic [31:0] hdr;
        write_regs(MODE_EXTRACT, 24'($urandom), 25'($urandom));
        for (int p = 0; p < 4; p++) begin
            set_pressure(p);
            budget = pixels_sent + 110;
            while (pixels_sent < budget) begin
                sel = $urandom_range(0, 99);
                if (sel < 70) hdr = $urandom_range(1, 12);
                else if (sel < 78) hdr = '0;
                else if (sel < 84) hdr = $urandom_range(10001, 32'h7FFF_FFFF);
                else if (sel < 90) hdr = {1'b1, 31'($urandom)};
                else if (sel < 95) hdr = 32'd10000;
                else hdr = $urandom;
                if (hdr >= 32'd1 && hdr <= 32'd12) begin
                    body = 2 * int'(hdr) + $urandom_range(0, 3);
                    if ($urandom_range(0, 9) == 0) body = $urandom_range(0, body);
                end else begin
                    body = $urandom_range(0, 6);
                end
                send_extract_frame(hdr, body, $urandom_range(0, 19) != 0);
            end
        end
    endtask

    task automatic test_random_hide();
        int          budget, n;
        logic [23:0] len;
        logic [24:0] total;
        logic [25:0] need;
        for (int p = 0; p < 4; p++) begin
            set_pressure(p);
            budget = pixels_sent + 80;
            while (pixels_sent < budget) begin
                pick_hide_setup(len, total);
                write_regs(MODE_HIDE, len, total);
                need = {1'b0, len, 1'b0} + 26'd8;
                if (need > {1'b0, total}) n = $urandom_range(1, 5);
                else if (need <= 26'd40) n = int'(need) + $urandom_range(0, 3);
                else n = $urandom_range(10, 24);
                send_hide_frame(n, $urandom_range(0, 19) != 0);
            end
        end
    endtask

    // Mode flips in the middle of a frame act on the state reached so far
    task automatic test_mode_switch();
        logic [23:0] len;
        logic [24:0] total;
        logic [31:0] hdr;
        int          k;
        for (int it = 0; it < 6; it++) begin
            set_pressure((it % 2 == 0) ? 0 : 3);
            pick_hide_setup(len, total);
            if ($urandom_range(0, 1) == 0) begin
                len   = 24'($urandom_range(0, 4));
                total = 25'($urandom_range(8, 40));
            end
            write_regs(MODE_EXTRACT, len, total);
            hdr = ($urandom_range(0, 4) == 0) ? $urandom : $urandom_range(1, 6);
            k = $urandom_range(1, 14);
            for (int i = 0; i < k; i++) begin
                send_nibble(i == 0, (i < 8) ? hdr[31 - 4 * i -: 4] : 4'($urandom));
            end
            write_regs(MODE_HIDE, len, total);
            send_hide_frame($urandom_range(1, 8), 1'b0);
            write_regs(MODE_EXTRACT, len, total);
            for (int i = 0; i < $urandom_range(1, 6); i++) send_nibble(1'b0, 4'($urandom));
        end
    endtask

    initial begin
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed_extract();
        test_directed_hide();
        test_random_extract();
        test_random_hide();
        test_mode_switch();
        quiesce();
        repeat (16) @(posedge aclk);
        $display("Sent %0d pixels over %0d register settings, checked %0d output items.",
                 pixels_sent, reg_sets, results_seen);
        $display("Recovered %0d message bytes, saw %0d end-of-message marks, %0d mismatches.",
                 bytes_seen, lasts_seen, mismatches);
        if (mismatches == 0 && pending_pixels.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #2_000_000;
        $display("Timeout with %0d items outstanding", pending_pixels.size());
        $display("RESULT: ERROR");
        $finish;
    end

endmodule
